// File: design/osc_pkg.sv
// ----------------------------------------------------------------------------
// osc_pkg: omni base speed control shared types and constants
// Command kinds, direction codes, register map, per-wheel kinematic
// coefficients (Q16) and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package osc_pkg;

    localparam int N_LANES = 3;

    typedef enum logic [1:0] {
        KIND_DIR   = 2'd0,
        KIND_VEL   = 2'd1,
        KIND_WHEEL = 2'd2,
        KIND_PWM   = 2'd3
    } kind_t;

    localparam logic [3:0] DIR_FWD     = 4'd1;
    localparam logic [3:0] DIR_FWD_L   = 4'd2;
    localparam logic [3:0] DIR_LEFT    = 4'd3;
    localparam logic [3:0] DIR_BACK_L  = 4'd4;
    localparam logic [3:0] DIR_BACK    = 4'd5;
    localparam logic [3:0] DIR_BACK_R  = 4'd6;
    localparam logic [3:0] DIR_RIGHT   = 4'd7;
    localparam logic [3:0] DIR_FWD_R   = 4'd8;
    localparam logic [3:0] DIR_ROT_L   = 4'd9;
    localparam logic [3:0] DIR_ROT_R   = 4'd10;

    localparam logic [0:0] REG_JOG    = 1'b0;
    localparam logic [0:0] REG_PERIOD = 1'b1;

    localparam logic [7:0]  JOG_RST    = 8'd0;
    localparam logic [15:0] PERIOD_RST = 16'd7200;
    localparam logic [15:0] ROT_MUL    = 16'd13;

    localparam logic signed [15:0] Q_LEN = 16'sd13107;
    localparam logic signed [15:0] Q_YAW = 16'sd2621;
    localparam logic signed [33:0] Q_RND = 34'sd65535;

    localparam logic signed [31:0] ACC_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [17:0] cx;
        logic signed [17:0] cy;
    } coef_t;

    localparam coef_t LANE_COEF [N_LANES] = '{
        '{cx: 18'sd65536,  cy: 18'sd0},
        '{cx: -18'sd32768, cy: -18'sd56756},
        '{cx: -18'sd32768, cy: 18'sd56756}
    };

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] yaw;
        logic [2:0][15:0]   cmd;
        logic [2:0][15:0]   enc;
    } tick_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic        sat;
    } lane_out_t;

endpackage

// File: design/omni_three_wheel_speed_control.sv
// ----------------------------------------------------------------------------
// omni_three_wheel_speed_control: three-wheel omni base speed controller
// A word passes the command, product, sum, target, error and accumulator
// registers, then the result register. Throughput: one word per cycle while
// the result is not stalled; each wheel's PI accumulator is read and written
// in a single pipeline stage, so consecutive words chain directly. A stalled
// result freezes the whole pipeline until it is taken. Reset clears the PI
// state, the pipeline valids and the registers (jog speed 0, PWM period 7200).
// ----------------------------------------------------------------------------
module omni_three_wheel_speed_control (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // direction[3:0], cmd_a[19:4], cmd_b[35:20], cmd_c[51:36],
    // enc_a[67:52], enc_b[83:68], enc_c[99:84], yaw_rate[115:100], zero pad
    input  logic [119:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pwm_a_low, pwm_a_high, pwm_b_low, pwm_b_high, pwm_c_low, pwm_c_high
    // (16 bits each from bit 0)
    output logic [95:0]   m_tdata,
    // saturated
    output logic          m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic                 adv;
    logic [5:0]           vld_reg;
    logic [7:0]           jog_reg;
    logic [15:0]          period_reg;
    osc_pkg::tick_t       tick;
    osc_pkg::lane_out_t   lane_res [osc_pkg::N_LANES];
    logic                 m_tvalid_reg;
    logic [95:0]          m_tdata_reg;
    logic                 m_tuser_reg;
    logic [95:0]          m_tdata_next;
    logic                 m_tuser_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jog_reg    <= osc_pkg::JOG_RST;
            period_reg <= osc_pkg::PERIOD_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                osc_pkg::REG_JOG:    jog_reg    <= pwdata[7:0];
                osc_pkg::REG_PERIOD: period_reg <= pwdata[15:0];
                default:             jog_reg    <= jog_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            osc_pkg::REG_JOG:    prdata = {24'd0, jog_reg};
            osc_pkg::REG_PERIOD: prdata = {16'd0, period_reg};
            default:             prdata = '0;
        endcase
    end

    osc_cmd u_cmd (
        .aclk      (aclk),
        .adv       (adv),
        .jog_speed (jog_reg),
        .kind      (osc_pkg::kind_t'(s_tuser)),
        .direction (s_tdata[3:0]),
        .cmd_a     ($signed(s_tdata[19:4])),
        .cmd_b     ($signed(s_tdata[35:20])),
        .cmd_c     ($signed(s_tdata[51:36])),
        .enc_a     ($signed(s_tdata[67:52])),
        .enc_b     ($signed(s_tdata[83:68])),
        .enc_c     ($signed(s_tdata[99:84])),
        .yaw_rate  ($signed(s_tdata[115:100])),
        .tick      (tick)
    );

    for (genvar i = 0; i < osc_pkg::N_LANES; i++) begin : g_lane
        osc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .upd     (adv && vld_reg[4]),
            .coef    (osc_pkg::LANE_COEF[i]),
            .kind    (tick.kind),
            .vx      (tick.vx),
            .vy      (tick.vy),
            .vz      (tick.vz),
            .yaw     (tick.yaw),
            .cmd     ($signed(tick.cmd[i])),
            .enc     ($signed(tick.enc[i])),
            .period  (period_reg),
            .res     (lane_res[i])
        );
    end

    always_comb begin
        m_tdata_next = {lane_res[2].hi, lane_res[2].lo,
                        lane_res[1].hi, lane_res[1].lo,
                        lane_res[0].hi, lane_res[0].lo};
        m_tuser_next = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[4:0], s_tvalid};
            m_tvalid_reg <= vld_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipeline moved while the result word was stalled");

    a_word_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vld_reg[5]))
        else $error("result word appeared without a word in the last stage");

    a_pair_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[15:0] == period_reg || m_tdata[31:16] == period_reg) &&
            (m_tdata[47:32] == period_reg || m_tdata[63:48] == period_reg) &&
            (m_tdata[79:64] == period_reg || m_tdata[95:80] == period_reg))
        else $error("compare pair lost its full-scale side");

endmodule

// File: design/osc_cmd.sv
// ----------------------------------------------------------------------------
// osc_cmd: command decode stage
// Turns a direction code or a serial velocity into body velocities and
// registers them with the per-wheel commands and encoder counts.
// ----------------------------------------------------------------------------
module osc_cmd (
    input  logic                aclk,
    input  logic                adv,
    input  logic [7:0]          jog_speed,
    input  osc_pkg::kind_t      kind,
    input  logic [3:0]          direction,
    input  logic signed [15:0]  cmd_a,
    input  logic signed [15:0]  cmd_b,
    input  logic signed [15:0]  cmd_c,
    input  logic signed [15:0]  enc_a,
    input  logic signed [15:0]  enc_b,
    input  logic signed [15:0]  enc_c,
    input  logic signed [15:0]  yaw_rate,
    output osc_pkg::tick_t      tick
);

    logic signed [15:0] v;
    logic signed [15:0] rot;
    logic signed [15:0] dvx;
    logic signed [15:0] dvy;
    logic signed [15:0] dvz;
    osc_pkg::tick_t     tick_next;
    osc_pkg::tick_t     tick_reg;

    always_comb begin
        v   = $signed({8'd0, jog_speed});
        rot = $signed(16'({8'd0, jog_speed} * osc_pkg::ROT_MUL));
        dvx = '0;
        dvy = '0;
        dvz = '0;
        unique case (direction)
            osc_pkg::DIR_FWD: begin
                dvy = v;
            end
            osc_pkg::DIR_FWD_L: begin
                dvx = -v;
                dvy = v;
            end
            osc_pkg::DIR_LEFT: begin
                dvx = -v;
            end
            osc_pkg::DIR_BACK_L: begin
                dvx = -v;
                dvy = -v;
            end
            osc_pkg::DIR_BACK: begin
                dvy = -v;
            end
            osc_pkg::DIR_BACK_R: begin
                dvx = v;
                dvy = -v;
            end
            osc_pkg::DIR_RIGHT: begin
                dvx = v;
            end
            osc_pkg::DIR_FWD_R: begin
                dvx = v;
                dvy = v;
            end
            osc_pkg::DIR_ROT_L: begin
                dvz = rot;
            end
            osc_pkg::DIR_ROT_R: begin
                dvz = -rot;
            end
            default: begin
                dvx = '0;
            end
        endcase
    end

    always_comb begin
        tick_next.kind = kind;
        tick_next.yaw  = yaw_rate;
        tick_next.cmd  = {cmd_c, cmd_b, cmd_a};
        tick_next.enc  = {enc_c, enc_b, enc_a};
        if (kind == osc_pkg::KIND_VEL) begin
            tick_next.vx = cmd_a;
            tick_next.vy = cmd_b;
            tick_next.vz = cmd_c;
        end else begin
            tick_next.vx = dvx;
            tick_next.vy = dvy;
            tick_next.vz = dvz;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tick_reg <= tick_next;
        end
    end

    assign tick = tick_reg;

endmodule

// File: design/osc_lane.sv
// ----------------------------------------------------------------------------
// osc_lane: one wheel's target, PI controller and H-bridge compare pair
// Kinematic products, Q16 sum with truncation toward zero, error, saturating
// incremental PI accumulator, then drive clamp and compare split.
// ----------------------------------------------------------------------------
module osc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  upd,
    input  osc_pkg::coef_t        coef,
    input  osc_pkg::kind_t        kind,
    input  logic signed [15:0]    vx,
    input  logic signed [15:0]    vy,
    input  logic signed [15:0]    vz,
    input  logic signed [15:0]    yaw,
    input  logic signed [15:0]    cmd,
    input  logic signed [15:0]    enc,
    input  logic [15:0]           period,
    output osc_pkg::lane_out_t    res
);

    // products
    logic signed [33:0] px_reg;
    logic signed [33:0] py_reg;
    logic signed [33:0] pz_reg;
    logic signed [33:0] pw_reg;
    osc_pkg::kind_t     kind2_reg;
    logic signed [15:0] cmd2_reg;
    logic signed [15:0] enc2_reg;

    // sum
    logic signed [33:0] sum3_reg;
    osc_pkg::kind_t     kind3_reg;
    logic signed [15:0] cmd3_reg;
    logic signed [15:0] enc3_reg;

    // target
    logic signed [33:0] biased;
    logic signed [33:0] trunc;
    logic signed [18:0] tgt_next;
    logic signed [18:0] tgt_reg;
    osc_pkg::kind_t     kind4_reg;
    logic signed [15:0] cmd4_reg;
    logic signed [15:0] enc4_reg;

    // error
    logic signed [18:0] err_reg;
    osc_pkg::kind_t     kind5_reg;
    logic signed [15:0] cmd5_reg;

    // accumulator
    logic signed [21:0] delta;
    logic signed [33:0] acc_sum;
    logic               acc_sat;
    logic signed [31:0] acc_next;
    logic signed [31:0] acc_reg;
    logic signed [18:0] prev_reg;
    logic signed [31:0] accd_reg;
    logic               asat_reg;
    logic               ovr_reg;
    logic signed [15:0] cmd6_reg;

    // drive
    logic signed [31:0] draw;
    logic signed [31:0] ps;
    logic signed [16:0] drv;
    logic               clamp;

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg    <= 34'(coef.cx) * 34'(vx);
            py_reg    <= 34'(coef.cy) * 34'(vy);
            pz_reg    <= 34'(osc_pkg::Q_LEN) * 34'(vz);
            pw_reg    <= 34'(osc_pkg::Q_YAW) * 34'(yaw);
            kind2_reg <= kind;
            cmd2_reg  <= cmd;
            enc2_reg  <= enc;

            sum3_reg  <= px_reg + py_reg + pz_reg - pw_reg;
            kind3_reg <= kind2_reg;
            cmd3_reg  <= cmd2_reg;
            enc3_reg  <= enc2_reg;

            tgt_reg   <= tgt_next;
            kind4_reg <= kind3_reg;
            cmd4_reg  <= cmd3_reg;
            enc4_reg  <= enc3_reg;

            err_reg   <= -19'(enc4_reg) - tgt_reg;
            kind5_reg <= kind4_reg;
            cmd5_reg  <= cmd4_reg;

            accd_reg  <= acc_next;
            asat_reg  <= acc_sat;
            ovr_reg   <= (kind5_reg == osc_pkg::KIND_PWM);
            cmd6_reg  <= cmd5_reg;
        end
    end

    always_comb begin
        biased = sum3_reg + (sum3_reg[33] ? osc_pkg::Q_RND : 34'sd0);
        trunc  = biased >>> 16;
        if (kind3_reg == osc_pkg::KIND_WHEEL) begin
            tgt_next = 19'(cmd3_reg);
        end else begin
            tgt_next = 19'(trunc);
        end
    end

    always_comb begin
        delta   = (22'(err_reg) <<< 2) + 22'(err_reg) - (22'(prev_reg) <<< 1);
        acc_sum = 34'(acc_reg) + 34'(delta);
        acc_sat = (acc_sum[33:31] != 3'b000) && (acc_sum[33:31] != 3'b111);
        if (!acc_sat) begin
            acc_next = acc_sum[31:0];
        end else if (acc_sum[33]) begin
            acc_next = osc_pkg::ACC_MIN;
        end else begin
            acc_next = osc_pkg::ACC_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end else if (upd) begin
            acc_reg  <= acc_next;
            prev_reg <= err_reg;
        end
    end

    always_comb begin
        draw = ovr_reg ? 32'(cmd6_reg) : accd_reg;
        ps   = $signed({16'd0, period});
        priority if (draw > ps) begin
            drv   = 17'(ps);
            clamp = 1'b1;
        end else if (draw < -ps) begin
            drv   = 17'(-ps);
            clamp = 1'b1;
        end else begin
            drv   = 17'(draw);
            clamp = 1'b0;
        end
        if (drv > 17'sd0) begin
            res.lo = period - drv[15:0];
            res.hi = period;
        end else begin
            res.lo = period;
            res.hi = period + drv[15:0];
        end
        res.sat = asat_reg | clamp;
    end

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd |=> $stable(acc_reg) && $stable(prev_reg))
        else $error("PI state changed without an update");

endmodule

// File: verif/wheel_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_drive_checker: result checker for the omni base speed controller
// Watches the tick and compare-value streams and the register port. For each
// accepted tick it runs its own kinematics and per-wheel PI model to work out
// the compare pairs and clamp flag, queues them, and compares every result
// word field by field against the oldest queued frame.
// ----------------------------------------------------------------------------
module wheel_drive_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [119:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [95:0]   m_tdata,
    input  logic          m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            mismatches,
    output int            outstanding,
    output int            words_checked,
    output int            clamp_words
);

    localparam longint K_ONE  = 65536;
    localparam longint K_HALF = 32768;
    localparam longint K_SQ3H = 56756;
    localparam longint K_ROT  = 13107;
    localparam longint K_YAW  = 2621;
    localparam longint ERR_HI = 262143;
    localparam longint ERR_LO = -262144;
    localparam longint ACC_HI = 64'sh7fff_ffff;
    localparam longint ACC_LO = -64'sh8000_0000;

    // dir[3:0], cmd a..c, enc a..c, yaw (16 bits each), pad
    typedef struct packed {
        logic [3:0]       pad;
        logic [15:0]      yaw;
        logic [2:0][15:0] enc;
        logic [2:0][15:0] cmd;
        logic [3:0]       dir;
    } tick_word_t;

    // cmp[2w] is the low compare of wheel w, cmp[2w+1] the high compare
    typedef struct packed {
        logic             sat;
        logic [5:0][15:0] cmp;
    } pwm_frame_t;

    logic [7:0]         jog_speed;
    logic [15:0]        pwm_period;
    logic signed [31:0] pi_acc [3];
    logic signed [18:0] pi_err [3];
    pwm_frame_t         frame_q [$];
    int                 err_cnt;
    int                 seen;
    int                 clamped;
    string field_name [6] = '{"pwm_a_low", "pwm_a_high", "pwm_b_low",
                              "pwm_b_high", "pwm_c_low", "pwm_c_high"};

    function automatic pwm_frame_t predict_drive(input osc_pkg::kind_t kind,
                                                 input tick_word_t tw);
        longint cmd [3];
        longint enc [3];
        longint tgt [3];
        longint vx, vy, vz, yaw, jog, per, common, err, acc, drv;
        pwm_frame_t r;
        int w;
        r = '0;
        jog = longint'(jog_speed);
        per = longint'(pwm_period);
        yaw = longint'($signed(tw.yaw));
        for (w = 0; w < 3; w++) begin
            cmd[w] = longint'($signed(tw.cmd[w]));
            enc[w] = -longint'($signed(tw.enc[w]));
        end
        vx = 0;
        vy = 0;
        vz = 0;
        case (tw.dir)
            osc_pkg::DIR_FWD:    vy = jog;
            osc_pkg::DIR_FWD_L:  begin vx = -jog; vy = jog; end
            osc_pkg::DIR_LEFT:   vx = -jog;
            osc_pkg::DIR_BACK_L: begin vx = -jog; vy = -jog; end
            osc_pkg::DIR_BACK:   vy = -jog;
            osc_pkg::DIR_BACK_R: begin vx = jog; vy = -jog; end
            osc_pkg::DIR_RIGHT:  vx = jog;
            osc_pkg::DIR_FWD_R:  begin vx = jog; vy = jog; end
            osc_pkg::DIR_ROT_L:  vz = jog * longint'(osc_pkg::ROT_MUL);
            osc_pkg::DIR_ROT_R:  vz = -jog * longint'(osc_pkg::ROT_MUL);
            default:    ;
        endcase
        if (kind == osc_pkg::KIND_VEL) begin
            vx = cmd[0];
            vy = cmd[1];
            vz = cmd[2];
        end
        common = K_ROT * vz - K_YAW * yaw;
        tgt[0] = (K_ONE * vx + common) / K_ONE;
        tgt[1] = (-K_HALF * vx - K_SQ3H * vy + common) / K_ONE;
        tgt[2] = (-K_HALF * vx + K_SQ3H * vy + common) / K_ONE;
        for (w = 0; w < 3; w++) begin
            if (kind == osc_pkg::KIND_WHEEL) tgt[w] = cmd[w];
            err = enc[w] - tgt[w];
            if (err > ERR_HI) err = ERR_HI;
            if (err < ERR_LO) err = ERR_LO;
            acc = longint'(pi_acc[w]) + 2 * (err - longint'(pi_err[w])) + 3 * err;
            if (acc > ACC_HI) begin
                acc = ACC_HI;
                r.sat = 1'b1;
            end
            if (acc < ACC_LO) begin
                acc = ACC_LO;
                r.sat = 1'b1;
            end
            pi_acc[w] = acc[31:0];
            pi_err[w] = err[18:0];
            drv = (kind == osc_pkg::KIND_PWM) ? cmd[w] : acc;
            if (drv > per) begin
                drv = per;
                r.sat = 1'b1;
            end
            if (drv < -per) begin
                drv = -per;
                r.sat = 1'b1;
            end
            if (drv > 0) begin
                r.cmp[2*w]   = 16'(per - drv);
                r.cmp[2*w+1] = 16'(per);
            end else begin
                r.cmp[2*w]   = 16'(per);
                r.cmp[2*w+1] = 16'(per + drv);
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("word %0d %s: expected %0d, got %0d", seen, what, want, got);
    endtask

    always @(posedge aclk) begin
        pwm_frame_t want;
        int i;
        if (!aresetn) begin
            jog_speed  = osc_pkg::JOG_RST;
            pwm_period = osc_pkg::PERIOD_RST;
            for (i = 0; i < 3; i++) begin
                pi_acc[i] = '0;
                pi_err[i] = '0;
            end
            frame_q.delete();
            err_cnt = 0;
            seen    = 0;
            clamped = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2:2] == osc_pkg::REG_JOG) jog_speed = pwdata[7:0];
                else if (paddr[2:2] == osc_pkg::REG_PERIOD) pwm_period = pwdata[15:0];
            end
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("word %0d arrived with nothing expected", seen);
                end else begin
                    want = frame_q.pop_front();
                    for (i = 0; i < 6; i++)
                        if (m_tdata[16*i +: 16] !== want.cmp[i])
                            note_mismatch(field_name[i], want.cmp[i], m_tdata[16*i +: 16]);
                    if (m_tuser !== want.sat)
                        note_mismatch("saturated", want.sat, m_tuser);
                    if (want.sat) clamped++;
                end
                seen++;
            end
            if (s_tvalid && s_tready)
                frame_q.push_back(predict_drive(osc_pkg::kind_t'(s_tuser),
                                                tick_word_t'(s_tdata)));
        end
        mismatches    <= err_cnt;
        outstanding   <= frame_q.size();
        words_checked <= seen;
        clamp_words   <= clamped;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the three-wheel omni speed controller
// Drives control ticks and register writes, with random source gaps and sink
// stalls, through a directed sweep of every kind and direction, random ticks
// over nine jog/period settings, and a run of one-sided wheel errors that
// winds the PI accumulators up. Checking is done by wheel_drive_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_SEGS       = 9;
    localparam int SEG_WORDS    = 130;
    localparam int WINDUP_WORDS = 150;
    localparam logic [3:0] DIR_STOP = 4'd0;
    localparam logic [7:0]  SEG_JOG [N_SEGS] = '{
        8'd255, 8'd0, 8'd1, 8'd128, 8'd255, 8'd77, 8'd200, 8'd255, 8'd13
    };
    localparam logic [15:0] SEG_PERIOD [N_SEGS] = '{
        16'd1, 16'd65535, 16'd0, 16'd7200, 16'd300, 16'd65535, 16'd1000, 16'd0, 16'd40000
    };

    typedef struct packed {
        logic [3:0]       pad;
        logic [15:0]      yaw;
        logic [2:0][15:0] enc;
        logic [2:0][15:0] cmd;
        logic [3:0]       dir;
    } tick_word_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [119:0]  s_tdata  = '0;
    logic [1:0]    s_tuser  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [95:0]   m_tdata;
    logic          m_tuser;
    logic          psel     = 1'b0;
    logic          penable  = 1'b0;
    logic          pwrite   = 1'b0;
    logic [2:0]    paddr    = '0;
    logic [31:0]   pwdata   = '0;
    logic [31:0]   prdata;
    logic          pready;
    int            mismatches;
    int            outstanding;
    int            words_checked;
    int            clamp_words;
    int            src_idle_pct = 0;
    int            snk_idle_pct = 0;
    int            cycle_count  = 0;
    int            settings_used = 0;

    always #4 aclk = ~aclk;

    omni_three_wheel_speed_control u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wheel_drive_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .clamp_words   (clamp_words)
    );

    function automatic tick_word_t make_tick(input logic [3:0] dir,
                                             input logic [15:0] ca, cb, cc,
                                             input logic [15:0] ea, eb, ec,
                                             input logic [15:0] yaw);
        tick_word_t tw;
        tw = '0;
        tw.dir = dir;
        tw.cmd = {cc, cb, ca};
        tw.enc = {ec, eb, ea};
        tw.yaw = yaw;
        return tw;
    endfunction

    // half of the values small so the PI loop wanders around zero, the rest full range and rails
    function automatic logic [15:0] rand_s16();
        case ($urandom_range(3))
            0, 1: return 16'($urandom_range(1024)) - 16'd512;
            2: return 16'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic set_idle(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_idle_pct <= snk_pct;
    endtask

    task automatic send_tick(input osc_pkg::kind_t kind, input tick_word_t tw);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tw;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic apply_settings(input logic [7:0] jog, input logic [15:0] period);
        drain();
        write_reg(osc_pkg::REG_JOG, {24'd0, jog});
        write_reg(osc_pkg::REG_PERIOD, {16'd0, period});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int d;
        int seg;
        set_idle(28, 53);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // reset register values
        send_tick(osc_pkg::KIND_DIR, make_tick(osc_pkg::DIR_FWD, '0, '0, '0,
                                      16'h0100, 16'hff00, 16'h0010, 16'h0200));
        send_tick(osc_pkg::KIND_VEL, make_tick(DIR_STOP, 16'h1234, 16'hedcb, 16'h0400,
                                      16'h0000, 16'h8000, 16'h7fff, 16'hfc00));

        apply_settings(8'd255, 16'd65535);
        for (d = 0; d < 16; d++)
            send_tick(osc_pkg::KIND_DIR, make_tick(4'(d), rand_s16(), rand_s16(), rand_s16(),
                                          d[0] ? 16'h7fff : 16'h8000,
                                          d[1] ? 16'h7fff : 16'h8000,
                                          d[2] ? 16'h0000 : 16'hffff,
                                          d[3] ? 16'h8000 : 16'h7fff));
        send_tick(osc_pkg::KIND_VEL, make_tick(DIR_STOP, 16'h7fff, 16'h7fff, 16'h7fff,
                                      16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_tick(osc_pkg::KIND_VEL, make_tick(DIR_STOP, 16'h8000, 16'h8000, 16'h8000,
                                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_tick(osc_pkg::KIND_WHEEL, make_tick(osc_pkg::DIR_ROT_L, 16'h8000, 16'h8000,
                                        16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0000));
        send_tick(osc_pkg::KIND_WHEEL, make_tick(osc_pkg::DIR_ROT_R, 16'h7fff, 16'h7fff,
                                        16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff));
        send_tick(osc_pkg::KIND_PWM, make_tick(osc_pkg::DIR_FWD_R, 16'h7fff, 16'h8000,
                                      16'h0000, 16'h0040, 16'hffc0, 16'h0000, 16'h1000));
        send_tick(osc_pkg::KIND_PWM, make_tick(osc_pkg::DIR_BACK_L, 16'h8000, 16'h7fff,
                                      16'hffff, 16'hff00, 16'h0100, 16'h7fff, 16'hf000));

        for (seg = 0; seg < N_SEGS; seg++) begin
            case (seg / 3)
                0: set_idle(28, 53);
                1: set_idle(53, 28);
                default: set_idle(0, 0);
            endcase
            apply_settings(SEG_JOG[seg], SEG_PERIOD[seg]);
            repeat (SEG_WORDS)
                send_tick(osc_pkg::kind_t'($urandom_range(3)),
                          make_tick(4'($urandom_range(15)), rand_s16(), rand_s16(),
                                    rand_s16(), rand_s16(), rand_s16(), rand_s16(),
                                    rand_s16()));
        end

        // push A and B toward the positive rail and C toward the negative one
        apply_settings(8'($urandom), 16'd65535);
        repeat (WINDUP_WORDS)
            send_tick(osc_pkg::KIND_WHEEL, make_tick(4'($urandom_range(15)),
                                            16'h8000, 16'h8000, 16'h7fff,
                                            16'h8000, 16'h8000, 16'h7fff,
                                            16'($urandom)));

        drain();
        repeat (16) @(posedge aclk);
        $display("checked %0d result words over %0d register settings, all kinds",
                 words_checked, settings_used);
        $display("and directions, %0d words with a clamp, ending in a one-sided error run",
                 clamp_words);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words never arrived", mismatches, outstanding);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: omni_three_wheel_speed_control.f
design/osc_pkg.sv
design/osc_cmd.sv
design/osc_lane.sv
design/omni_three_wheel_speed_control.sv
verif/wheel_drive_checker.sv
verif/tb_top.sv
